// File: hdl/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Shared types, opcodes and sizing constants.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_W       = $clog2(PAGE_BYTES);
  localparam int SECT_W       = $clog2(SECTOR_BYTES);
  localparam int BIDX_W       = PAGE_W + 1;
  localparam int MAX_RES      = 4;
  localparam int QDEPTH       = 2;

  localparam logic [7:0]  OP_JEDEC = 8'h9F;
  localparam logic [7:0]  OP_RDSR  = 8'h05;
  localparam logic [7:0]  OP_WREN  = 8'h06;
  localparam logic [7:0]  OP_WRDI  = 8'h04;
  localparam logic [7:0]  OP_READ  = 8'h03;
  localparam logic [7:0]  OP_ERASE = 8'h20;
  localparam logic [7:0]  OP_PROG  = 8'h02;
  localparam logic [7:0]  DUMMY    = 8'hFF;
  localparam logic [25:0] ADDR_END = 26'h1000000;

  localparam logic [15:0] RST_POLL_LIMIT = 16'd1000;
  localparam logic [15:0] RST_INTERVAL   = 16'd10;
  localparam logic [7:0]  RST_BUSY_MASK  = 8'h01;
  localparam logic [7:0]  RST_WEL_MASK   = 8'h02;

  typedef enum logic [2:0] {
    CMD_ID      = 3'd0,
    CMD_STATUS  = 3'd1,
    CMD_READ    = 3'd2,
    CMD_ERASE   = 3'd3,
    CMD_PROGRAM = 3'd4,
    CMD_PAYLOAD = 3'd5,
    CMD_REPLY   = 3'd6,
    CMD_TICK    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_END  = 2'd1,
    KIND_HOST = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_POLL_LIMIT = 2'd0,
    REG_INTERVAL   = 2'd1,
    REG_BUSY_MASK  = 2'd2,
    REG_WEL_MASK   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [24:0] length;
    logic [7:0]  data_byte;
    logic [7:0]  reply_byte;
    logic        reply_ok;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic [7:0] host_byte;
    logic       success;
    logic       last;
  } out_t;

  typedef struct packed {
    out_t [MAX_RES-1:0] item;
    logic [2:0]         count;
  } res_list_t;

  function automatic out_t make_res(kind_t k, logic [7:0] b, logic [7:0] h, logic ok);
    out_t r;
    r.kind      = k;
    r.bus_byte  = b;
    r.host_byte = h;
    r.success   = ok;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/snfcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module snfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/snfcs_front.sv
// ----------------------------------------------------------------------------
// Front queue
// Accepts input items and holds them for the sequencer.
// ----------------------------------------------------------------------------
module snfcs_front import snfcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  output in_t  q_data,
  input  logic q_pop
);

  in_t        ent_r [QDEPTH];
  logic [0:0] wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= in_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/snfcs_seq.sv
// ----------------------------------------------------------------------------
// Sequencer
// Steps the flash frame state machine by one item, builds its results.
// ----------------------------------------------------------------------------
module snfcs_seq import snfcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       step,
  input  in_t        item,
  output res_list_t  res
);

  typedef enum logic [12:0] {
    PH_IDLE      = 13'h0001,
    PH_ID        = 13'h0002,
    PH_STATUS    = 13'h0004,
    PH_READ      = 13'h0008,
    PH_PRE_POLL  = 13'h0010,
    PH_PRE_WAIT  = 13'h0020,
    PH_POST_POLL = 13'h0040,
    PH_POST_WAIT = 13'h0080,
    PH_WREN      = 13'h0100,
    PH_WEL       = 13'h0200,
    PH_MAIN      = 13'h0400,
    PH_WRDI      = 13'h0800,
    PH_WRDI_ST   = 13'h1000
  } phase_t;

  logic [15:0] poll_limit_r, interval_r;
  logic [7:0]  busy_mask_r, wel_mask_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [23:0] tgt_r, tgt_nxt;
  logic [24:0] left_r, left_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] polls_r, polls_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;

  logic        wr_en;
  logic [7:0]  rd_data;

  snfcs_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bidx_r[PAGE_W-1:0]),
    .wr_data (item.data_byte),
    .rd_addr (bidx_nxt[PAGE_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    out_t [MAX_RES-1:0] r;
    logic [2:0]  n;
    logic        fin, fin_ok, poll, post, start;
    phase_t      start_ph;
    logic [7:0]  start_op;
    logic [25:0] end_sum;
    logic [25:0] page_sum;
    logic        range_ok;
    logic [7:0]  rb;
    logic [7:0]  abyte;

    r         = '0;
    n         = 3'd0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    poll      = 1'b0;
    post      = (phase_r == PH_POST_POLL) || (phase_r == PH_POST_WAIT);
    start     = 1'b0;
    start_ph  = PH_IDLE;
    start_op  = OP_RDSR;
    wr_en     = 1'b0;
    rb        = item.reply_byte;
    end_sum   = 26'(item.address[23:0]) + 26'(item.length);
    page_sum  = 26'(item.address[PAGE_W-1:0]) + 26'(item.length);
    range_ok  = (item.length != 25'd0) && (item.address[31:24] == 8'd0) &&
                (end_sum <= ADDR_END);
    case (pos_r)
      3'd0:    abyte = tgt_r[23:16];
      3'd1:    abyte = tgt_r[15:8];
      default: abyte = tgt_r[7:0];
    endcase

    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    tgt_nxt   = tgt_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    polls_nxt = polls_r;
    ticks_nxt = ticks_r;
    bidx_nxt  = bidx_r;

    if (step) begin
      if (phase_r == PH_IDLE) begin
        if (item.command == CMD_PAYLOAD) begin
          if (bidx_r < BIDX_W'(PAGE_BYTES)) begin
            wr_en    = 1'b1;
            bidx_nxt = bidx_r + 1'b1;
          end
        end else if (item.command <= CMD_PROGRAM) begin
          kind_nxt = item.command;
          tgt_nxt  = item.address[23:0];
          left_nxt = item.length;
          case (item.command)
            CMD_ID: begin
              start = 1'b1; start_ph = PH_ID; start_op = OP_JEDEC;
            end
            CMD_STATUS: begin
              start = 1'b1; start_ph = PH_STATUS; start_op = OP_RDSR;
            end
            CMD_READ: begin
              if (range_ok) begin
                start = 1'b1; start_ph = PH_READ; start_op = OP_READ;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_ERASE: begin
              if (item.address[31:24] == 8'd0 && item.address[SECT_W-1:0] == '0) begin
                polls_nxt = 16'd0; poll = 1'b1; post = 1'b0;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              bidx_nxt = '0;
              if (range_ok && page_sum <= 26'(PAGE_BYTES)) begin
                polls_nxt = 16'd0; poll = 1'b1; post = 1'b0;
              end else begin
                fin = 1'b1;
              end
            end
          endcase
        end
      end else if (item.command == CMD_REPLY &&
                   phase_r != PH_PRE_WAIT && phase_r != PH_POST_WAIT) begin
        if (!item.reply_ok) begin
          r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
          if (phase_r == PH_MAIN) begin
            start = 1'b1; start_ph = PH_WRDI; start_op = OP_WRDI;
          end else begin
            fin = 1'b1;
          end
        end else begin
          case (phase_r)
            PH_ID: begin
              if (pos_r != 3'd0) begin
                r[n[1:0]] = make_res(KIND_HOST, 8'd0, rb, 1'b0); n = n + 3'd1;
              end
              if (pos_r >= 3'd3) begin
                r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                fin = 1'b1; fin_ok = 1'b1;
              end else begin
                pos_nxt = pos_r + 3'd1;
                r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
              end
            end
            PH_STATUS, PH_WRDI_ST: begin
              if (pos_r == 3'd0) begin
                pos_nxt = 3'd1;
                r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
              end else begin
                if (phase_r == PH_STATUS) begin
                  r[n[1:0]] = make_res(KIND_HOST, 8'd0, rb, 1'b0); n = n + 3'd1;
                  fin_ok = 1'b1;
                end
                r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                fin = 1'b1;
              end
            end
            PH_READ: begin
              if (pos_r < 3'd3) begin
                r[n[1:0]] = make_res(KIND_SEND, abyte, 8'd0, 1'b0); n = n + 3'd1;
                pos_nxt = pos_r + 3'd1;
              end else if (pos_r == 3'd3) begin
                pos_nxt = 3'd4;
                r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
              end else begin
                r[n[1:0]] = make_res(KIND_HOST, 8'd0, rb, 1'b0); n = n + 3'd1;
                left_nxt = left_r - 25'd1;
                if (left_nxt == 25'd0) begin
                  r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                  fin = 1'b1; fin_ok = 1'b1;
                end else begin
                  r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
                end
              end
            end
            PH_PRE_POLL, PH_POST_POLL: begin
              if (pos_r == 3'd0) begin
                pos_nxt = 3'd1;
                r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
              end else begin
                r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                if ((rb & busy_mask_r) != 8'd0) begin
                  if (polls_r != 16'hFFFF) begin
                    polls_nxt = polls_r + 16'd1;
                  end
                  ticks_nxt = 16'd0;
                  phase_nxt = post ? PH_POST_WAIT : PH_PRE_WAIT;
                  if (interval_r == 16'd0) begin
                    poll = 1'b1;
                  end
                end else if (post) begin
                  fin = 1'b1; fin_ok = 1'b1;
                end else begin
                  start = 1'b1; start_ph = PH_WREN; start_op = OP_WREN;
                end
              end
            end
            PH_WREN, PH_WRDI: begin
              r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
              start = 1'b1; start_op = OP_RDSR;
              start_ph = (phase_r == PH_WREN) ? PH_WEL : PH_WRDI_ST;
            end
            PH_WEL: begin
              if (pos_r == 3'd0) begin
                pos_nxt = 3'd1;
                r[n[1:0]] = make_res(KIND_SEND, DUMMY, 8'd0, 1'b0); n = n + 3'd1;
              end else begin
                r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                if ((rb & wel_mask_r) != 8'd0) begin
                  start = 1'b1; start_ph = PH_MAIN;
                  start_op = (kind_r == CMD_ERASE) ? OP_ERASE : OP_PROG;
                end else begin
                  fin = 1'b1;
                end
              end
            end
            PH_MAIN: begin
              if (pos_r < 3'd3) begin
                r[n[1:0]] = make_res(KIND_SEND, abyte, 8'd0, 1'b0); n = n + 3'd1;
                pos_nxt = pos_r + 3'd1;
              end else begin
                if (pos_r == 3'd4) begin
                  left_nxt = left_r - 25'd1;
                end
                if (kind_r == CMD_ERASE || left_nxt == 25'd0) begin
                  r[n[1:0]] = make_res(KIND_END, 8'd0, 8'd0, 1'b0); n = n + 3'd1;
                  polls_nxt = 16'd0; poll = 1'b1; post = 1'b1;
                end else begin
                  pos_nxt = 3'd4;
                  r[n[1:0]] = make_res(KIND_SEND,
                    (bidx_r < BIDX_W'(PAGE_BYTES)) ? rd_data : 8'd0, 8'd0, 1'b0);
                  n = n + 3'd1;
                  bidx_nxt = bidx_r + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end else if (item.command == CMD_TICK &&
                   (phase_r == PH_PRE_WAIT || phase_r == PH_POST_WAIT)) begin
        if (ticks_r != 16'hFFFF) begin
          ticks_nxt = ticks_r + 16'd1;
        end
        if (ticks_nxt >= interval_r) begin
          poll = 1'b1;
        end
      end
    end

    if (poll) begin
      if (polls_nxt >= poll_limit_r) begin
        fin = 1'b1;
      end else begin
        start = 1'b1; start_op = OP_RDSR;
        start_ph = post ? PH_POST_POLL : PH_PRE_POLL;
      end
    end
    if (start) begin
      phase_nxt = start_ph;
      pos_nxt   = 3'd0;
      r[n[1:0]] = make_res(KIND_SEND, start_op, 8'd0, 1'b0); n = n + 3'd1;
    end
    if (fin) begin
      r[n[1:0]] = make_res(KIND_DONE, 8'd0, 8'd0, fin_ok); n = n + 3'd1;
      if (kind_nxt == CMD_PROGRAM) begin
        bidx_nxt = '0;
      end
      phase_nxt = PH_IDLE;
    end
    if (n != 3'd0) begin
      r[2'(n - 3'd1)].last = 1'b1;
    end
    res.item  = r;
    res.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= RST_POLL_LIMIT;
      interval_r   <= RST_INTERVAL;
      busy_mask_r  <= RST_BUSY_MASK;
      wel_mask_r   <= RST_WEL_MASK;
      phase_r      <= PH_IDLE;
      kind_r       <= 3'd0;
      tgt_r        <= 24'd0;
      left_r       <= 25'd0;
      pos_r        <= 3'd0;
      polls_r      <= 16'd0;
      ticks_r      <= 16'd0;
      bidx_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_POLL_LIMIT: poll_limit_r <= cfg_data;
          REG_INTERVAL:   interval_r   <= cfg_data;
          REG_BUSY_MASK:  busy_mask_r  <= cfg_data[7:0];
          REG_WEL_MASK:   wel_mask_r   <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      tgt_r   <= tgt_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      polls_r <= polls_nxt;
      ticks_r <= ticks_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

endmodule

// File: hdl/snfcs_out.sv
// ----------------------------------------------------------------------------
// Result stage
// Holds one item's results, handing out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module snfcs_out import snfcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_list_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  out_t [MAX_RES-1:0] item_r;
  logic [2:0]         cnt_r;
  logic [1:0]         idx_r;
  logic               pop_last;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = item_r[idx_r];
  assign pop_last  = out_valid && out_ready && (3'(idx_r) == cnt_r - 3'd1);
  assign free      = !out_valid || pop_last;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res.item;
    end
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.count;
      idx_r <= 2'd0;
    end else if (pop_last) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (3'(idx_r) < cnt_r))
    else $error("result index past count");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.count != 3'd0) |=> (out_valid && idx_r == 2'd0))
    else $error("loaded results not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_last && !load) |=> !out_valid)
    else $error("results linger after last pop");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (3'(idx_r) == cnt_r - 3'd1)))
    else $error("last flag misplaced");

endmodule

// File: hdl/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns host requests into chip-select framed flash byte streams.
// Flow: an accepted item is registered in the front queue and reaches the
//   sequencer once the result stage is free; its results are registered there.
// Throughput: one item per cycle while out_ready is high and each item yields
//   at most one result; else the result stage holds until all are taken.
// Reset: synchronous, active low; control and registers return to defaults,
//   page buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer import snfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic      q_valid, free, step;
  in_t       q_data;
  res_list_t res;

  assign cfg_ready = 1'b1;
  assign step      = q_valid && free;

  snfcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (step)
  );

  snfcs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (q_data),
    .res       (res)
  );

  snfcs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Drives host requests, payload bytes, bus replies and ticks, mostly shaped
// as well-formed flash sessions, under random idling on both channels. A
// built-in predictor computes every result, and each output item is checked
// in order, field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_spi_nor_flash_command_sequencer;
  import snfcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    PH_IDLE, PH_ID, PH_STATUS, PH_READ, PH_PRE_POLL, PH_PRE_WAIT,
    PH_POST_POLL, PH_POST_WAIT, PH_WREN, PH_WEL, PH_MAIN, PH_WRDI, PH_WRDI_ST
  } seq_phase_t;

  typedef struct {
    in_t  it;
    bit   typed;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  spi_nor_flash_command_sequencer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int errors = 0;
  bit calm = 1'b0;
  out_t flash_q[$];
  out_t step_q[$];

  // predictor state
  seq_phase_t ph;
  cmd_t rq_kind;
  logic [23:0] tgt_addr;
  logic [24:0] remaining;
  logic [2:0] fpos;
  logic [15:0] polls, ticks;
  logic [7:0] pbuf [PAGE_BYTES];
  logic [8:0] bidx;
  int loaded_top;
  logic [15:0] lim, ivl;
  logic [7:0] bmask, wmask;

  function automatic void post_res(kind_t k, logic [7:0] b, logic [7:0] h, logic ok);
    out_t r;
    r.kind = k;
    r.bus_byte = b;
    r.host_byte = h;
    r.success = ok;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void start_frame(seq_phase_t p, logic [7:0] op);
    ph = p;
    fpos = '0;
    post_res(KIND_SEND, op, 8'h00, 1'b0);
  endfunction

  function automatic void finish_req(logic ok);
    post_res(KIND_DONE, 8'h00, 8'h00, ok);
    if (rq_kind == CMD_PROGRAM) bidx = '0;
    ph = PH_IDLE;
  endfunction

  function automatic void poll_begin(bit post);
    if (polls >= lim) finish_req(1'b0);
    else start_frame(post ? PH_POST_POLL : PH_PRE_POLL, OP_RDSR);
  endfunction

  function automatic void wait_ready(bit post);
    polls = '0;
    poll_begin(post);
  endfunction

  function automatic void busy_seen(bit post);
    if (polls != 16'hFFFF) polls++;
    ticks = '0;
    ph = post ? PH_POST_WAIT : PH_PRE_WAIT;
    if (ivl == 0) poll_begin(post);
  endfunction

  function automatic void send_addr_byte(logic [2:0] p);
    logic [23:0] sh;
    sh = tgt_addr >> (16 - 8 * p);
    post_res(KIND_SEND, sh[7:0], 8'h00, 1'b0);
  endfunction

  function automatic void take_reply(logic [7:0] rb, logic ok);
    logic [2:0] p;
    bit post;
    p = fpos;
    post = (ph == PH_POST_POLL);
    if (!ok) begin
      post_res(KIND_END, 8'h00, 8'h00, 1'b0);
      if (ph == PH_MAIN) start_frame(PH_WRDI, OP_WRDI);
      else finish_req(1'b0);
      return;
    end
    case (ph)
      PH_ID: begin
        if (p != 0) post_res(KIND_HOST, 8'h00, rb, 1'b0);
        if (p >= 3) begin
          post_res(KIND_END, 8'h00, 8'h00, 1'b0);
          finish_req(1'b1);
        end else begin
          fpos = p + 1;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end
      end
      PH_STATUS: begin
        if (p == 0) begin
          fpos = 1;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end else begin
          post_res(KIND_HOST, 8'h00, rb, 1'b0);
          post_res(KIND_END, 8'h00, 8'h00, 1'b0);
          finish_req(1'b1);
        end
      end
      PH_READ: begin
        if (p < 3) begin
          send_addr_byte(p);
          fpos = p + 1;
        end else if (p == 3) begin
          fpos = 4;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end else begin
          post_res(KIND_HOST, 8'h00, rb, 1'b0);
          remaining = remaining - 1;
          if (remaining == 0) begin
            post_res(KIND_END, 8'h00, 8'h00, 1'b0);
            finish_req(1'b1);
          end else post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end
      end
      PH_PRE_POLL, PH_POST_POLL: begin
        if (p == 0) begin
          fpos = 1;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end else begin
          post_res(KIND_END, 8'h00, 8'h00, 1'b0);
          if ((rb & bmask) != 0) busy_seen(post);
          else if (post) finish_req(1'b1);
          else start_frame(PH_WREN, OP_WREN);
        end
      end
      PH_WREN: begin
        post_res(KIND_END, 8'h00, 8'h00, 1'b0);
        start_frame(PH_WEL, OP_RDSR);
      end
      PH_WEL: begin
        if (p == 0) begin
          fpos = 1;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end else begin
          post_res(KIND_END, 8'h00, 8'h00, 1'b0);
          if ((rb & wmask) != 0)
            start_frame(PH_MAIN, rq_kind == CMD_ERASE ? OP_ERASE : OP_PROG);
          else finish_req(1'b0);
        end
      end
      PH_MAIN: begin
        if (p < 3) begin
          send_addr_byte(p);
          fpos = p + 1;
        end else begin
          if (p == 4) remaining = remaining - 1;
          if (rq_kind == CMD_ERASE || remaining == 0) begin
            post_res(KIND_END, 8'h00, 8'h00, 1'b0);
            wait_ready(1'b1);
          end else begin
            fpos = 4;
            post_res(KIND_SEND, bidx < PAGE_BYTES ? pbuf[bidx[7:0]] : 8'h00, 8'h00, 1'b0);
            bidx++;
          end
        end
      end
      PH_WRDI: begin
        post_res(KIND_END, 8'h00, 8'h00, 1'b0);
        start_frame(PH_WRDI_ST, OP_RDSR);
      end
      PH_WRDI_ST: begin
        if (p == 0) begin
          fpos = 1;
          post_res(KIND_SEND, DUMMY, 8'h00, 1'b0);
        end else begin
          post_res(KIND_END, 8'h00, 8'h00, 1'b0);
          finish_req(1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit span_fits(logic [31:0] a, logic [24:0] n);
    if (n == 0 || a > 32'h00FF_FFFF) return 1'b0;
    return ({8'h00, n} - 33'd1) <= (33'h0FF_FFFF - {1'b0, a});
  endfunction

  function automatic void take_request(in_t x);
    cmd_t c;
    c = cmd_t'(x.command);
    if (c == CMD_PAYLOAD) begin
      if (bidx < PAGE_BYTES) begin
        pbuf[bidx[7:0]] = x.data_byte;
        bidx++;
        if (bidx > loaded_top) loaded_top = bidx;
      end
      return;
    end
    if (c > CMD_PROGRAM) return;
    rq_kind = c;
    tgt_addr = x.address[23:0];
    remaining = x.length;
    case (c)
      CMD_ID: start_frame(PH_ID, OP_JEDEC);
      CMD_STATUS: start_frame(PH_STATUS, OP_RDSR);
      CMD_READ: begin
        if (span_fits(x.address, x.length)) start_frame(PH_READ, OP_READ);
        else finish_req(1'b0);
      end
      CMD_ERASE: begin
        if (x.address <= 32'h00FF_FFFF && x.address % SECTOR_BYTES == 0) wait_ready(1'b0);
        else finish_req(1'b0);
      end
      default: begin
        bidx = '0;
        if (span_fits(x.address, x.length) && x.length <= PAGE_BYTES &&
            x.length <= PAGE_BYTES - (x.address % PAGE_BYTES))
          wait_ready(1'b0);
        else finish_req(1'b0);
      end
    endcase
  endfunction

  function automatic void flash_step(in_t x);
    cmd_t c;
    c = cmd_t'(x.command);
    step_q.delete();
    if (ph == PH_IDLE) take_request(x);
    else if (c == CMD_REPLY) begin
      if (ph != PH_PRE_WAIT && ph != PH_POST_WAIT) take_reply(x.reply_byte, x.reply_ok);
    end else if (c == CMD_TICK) begin
      if (ph == PH_PRE_WAIT || ph == PH_POST_WAIT) begin
        if (ticks != 16'hFFFF) ticks++;
        if (ticks >= ivl) poll_begin(ph == PH_POST_WAIT);
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  function automatic in_t mk(cmd_t c, logic [31:0] a, logic [24:0] n,
                             logic [7:0] db, logic [7:0] rb, logic ok);
    in_t x;
    x.command = c;
    x.address = a;
    x.length = n;
    x.data_byte = db;
    x.reply_byte = rb;
    x.reply_ok = ok;
    return x;
  endfunction

  function automatic out_t done_res(logic ok);
    out_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.success = ok;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_t send_res(logic [7:0] b);
    out_t r;
    r = '0;
    r.kind = KIND_SEND;
    r.bus_byte = b;
    r.last = 1'b1;
    return r;
  endfunction

  in_t plan_q[$];

  function automatic in_t noise();
    return mk(cmd_t'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom,
              $urandom_range(1));
  endfunction

  function automatic in_t next_item();
    int r, n, k;
    logic [31:0] a;
    logic [7:0] rb;
    if (plan_q.size() > 0) return plan_q.pop_front();
    r = $urandom_range(99);
    case (ph)
      PH_IDLE: begin
        if (r < 8) return mk(CMD_ID, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 16) return mk(CMD_STATUS, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 34) begin
          n = $urandom_range(8, 1);
          a = $urandom_range(10) == 0 ? 32'h00FF_FFFF - $urandom_range(9) : {8'h00, 24'($urandom)};
          return mk(CMD_READ, a, n, $urandom, $urandom, $urandom);
        end
        if (r < 50) begin
          a = {8'h00, 12'($urandom), 12'h000};
          if ($urandom_range(9) == 0) a = $urandom;
          return mk(CMD_ERASE, a, $urandom, $urandom, $urandom, $urandom);
        end
        if (r < 80) begin
          n = $urandom_range(16, 1);
          a = {8'h00, 16'($urandom), 8'(PAGE_BYTES - n - $urandom_range(PAGE_BYTES - n))};
          k = n + $urandom_range(3);
          for (int i = 0; i < k; i++)
            plan_q.push_back(mk(CMD_PAYLOAD, $urandom, $urandom, $urandom, $urandom, $urandom));
          plan_q.push_back(mk(CMD_PROGRAM, a, n, $urandom, $urandom, $urandom));
          return plan_q.pop_front();
        end
        if (r < 88) return noise();
        return mk(cmd_t'($urandom_range(4, 2)), $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      PH_PRE_WAIT, PH_POST_WAIT: begin
        if (r < 90) return mk(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
        return noise();
      end
      default: begin
        if (r < 4) return noise();
        rb = $urandom;
        if (ph == PH_PRE_POLL || ph == PH_POST_POLL)
          rb = $urandom_range(99) < 30 ? (rb | bmask) : (rb & ~bmask);
        else if (ph == PH_WEL)
          rb = $urandom_range(99) < 90 ? (rb | wmask) : (rb & ~wmask);
        return mk(CMD_REPLY, $urandom, $urandom, $urandom, rb, $urandom_range(99) < 97);
      end
    endcase
  endfunction

  task automatic push_item(in_t x);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    flash_step(x);
    foreach (step_q[i]) flash_q.push_back(step_q[i]);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POLL_LIMIT: lim = v;
      REG_INTERVAL: ivl = v;
      REG_BUSY_MASK: bmask = v[7:0];
      default: wmask = v[7:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (flash_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    if (rst_n && out_valid && out_ready) begin
      if (flash_q.size() == 0) begin
        $error("unexpected item kind=%0d", out_data.kind);
        errors++;
      end else begin
        out_t w;
        w = flash_q.pop_front();
        if (out_data.kind !== w.kind) begin
          $error("kind expected %0d got %0d", w.kind, out_data.kind); errors++;
        end
        if (out_data.bus_byte !== w.bus_byte) begin
          $error("bus_byte expected %h got %h", w.bus_byte, out_data.bus_byte); errors++;
        end
        if (out_data.host_byte !== w.host_byte) begin
          $error("host_byte expected %h got %h", w.host_byte, out_data.host_byte); errors++;
        end
        if (out_data.success !== w.success) begin
          $error("success expected %b got %b", w.success, out_data.success); errors++;
        end
        if (out_data.last !== w.last) begin
          $error("last expected %b got %b", w.last, out_data.last); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_spi_nor_flash_command_sequencer NOT OK");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    in_t x;
    int useful;
    logic [15:0] sets [4][4];
    sets = '{'{16'd1000, 16'd10, 16'h01, 16'h02},
             '{16'd1, 16'd0, 16'hFF, 16'h80},
             '{16'd65535, 16'd65535, 16'h00, 16'h00},
             '{16'd3, 16'd2, 16'h10, 16'h01}};
    ph = PH_IDLE; rq_kind = CMD_ID; tgt_addr = '0; remaining = '0; fpos = '0;
    polls = '0; ticks = '0; bidx = '0; loaded_top = 0;
    lim = RST_POLL_LIMIT; ivl = RST_INTERVAL; bmask = RST_BUSY_MASK; wmask = RST_WEL_MASK;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rw.typed = 0; rw.want = '0;
    rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_REPLY, 0, 0, 0, 8'hFF, 1); rows.push_back(rw);
    rw.it = mk(CMD_PAYLOAD, 0, 0, 8'h00, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_PAYLOAD, 32'hFFFF_FFFF, 25'h1FF_FFFF, 8'hFF, 8'hFF, 1); rows.push_back(rw);
    rw.typed = 1; rw.want = done_res(0);
    rw.it = mk(CMD_READ, 32'h0100_0000, 1, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_READ, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_READ, 32'h00FF_FFFF, 2, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_READ, 0, 25'h1FF_FFFF, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_ERASE, 32'h0000_1001, 1, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_PROGRAM, 32'h0000_00FF, 2, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_PROGRAM, 0, 257, 0, 0, 0); rows.push_back(rw);
    rw.want = send_res(OP_JEDEC);
    rw.it = mk(CMD_ID, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.typed = 0;
    foreach (sets[i]) begin
      rw.it = mk(CMD_REPLY, 0, 0, 0, 8'(8'h55 * i), 1); rows.push_back(rw);
    end
    rw.typed = 1; rw.want = send_res(OP_RDSR);
    rw.it = mk(CMD_STATUS, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.typed = 0;
    rw.it = mk(CMD_REPLY, 0, 0, 0, 8'h00, 1); rows.push_back(rw);
    rw.it = mk(CMD_REPLY, 0, 0, 0, 8'hFF, 1); rows.push_back(rw);
    rw.typed = 1; rw.want = send_res(OP_READ);
    rw.it = mk(CMD_READ, 32'h00FF_FFFF, 1, 0, 0, 0); rows.push_back(rw);
    rw.typed = 0;
    repeat (5) begin
      rw.it = mk(CMD_REPLY, 0, 0, 0, 8'hA5, 1); rows.push_back(rw);
    end
    rw.it = mk(CMD_ID, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CMD_REPLY, 0, 0, 0, 8'h00, 0); rows.push_back(rw);

    foreach (rows[i]) begin
      push_item(rows[i].it);
      if (rows[i].typed && (step_q.size() != 1 || step_q[0] != rows[i].want)) begin
        $error("directed row %0d: predictor disagrees with typed result", i);
        errors++;
      end
    end
    drain();

    useful = 0;
    foreach (sets[s]) begin
      for (int r = 0; r < 4; r++) write_reg(reg_idx_t'(r), sets[s][r]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      while (useful < 90 * (s + 1) || ph != PH_IDLE || plan_q.size() > 0) begin
        calm = (s == 2) && useful >= 200 && useful < 250;
        x = next_item();
        push_item(x);
        if (step_q.size() > 0 || (ph == PH_IDLE && x.command == CMD_PAYLOAD)) useful++;
      end
      calm = 1'b0;
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && flash_q.size() == 0) begin
      $display("tb_spi_nor_flash_command_sequencer OK");
    end else begin
      $display("tb_spi_nor_flash_command_sequencer NOT OK");
    end
    $finish;
  end

endmodule
